>>> design/dtdc_pkg.sv
// Package for the date to day count unit: shared struct, calendar constants
// and small table and divide-by-constant functions. Depends on nothing.
package dtdc_pkg;

	localparam logic [11:0] BaseYear      = 12'd1900;
	localparam logic [10:0] LeapsBefore   = 11'd460;
	localparam logic [10:0] Div25Recip    = 11'd1311;
	localparam int          Div25Shift    = 15;
	localparam logic [8:0]  DaysCommon    = 9'd365;

	localparam logic CalGregorian = 1'b1;
	localparam logic CalNoLeap    = 1'b0;

	// Partial results of one date, passed from the decode stage to the summing stage.
	typedef struct packed {
		logic [19:0] year_days;
		logic [9:0]  leap_days;
		logic [8:0]  month_days;
		logic [4:0]  day_off;
		logic        use_count;
		logic        bad;
	} dtdc_part_t;

	// Exact floor(v / 25) for any 10-bit v, by reciprocal multiplication.
	function automatic logic [5:0] div25(input logic [9:0] v);
		logic [20:0] prod;
		prod = {11'd0, v} * {10'd0, Div25Recip};
		return prod[20:Div25Shift];
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
			4'd2:                                        len = leap ? 5'd29 : 5'd28;
			default:                                     len = 5'd0;
		endcase
		return len;
	endfunction

	// Days in the year before the first of month m.
	function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
		logic [8:0] off;
		unique case (m)
			4'd1:    off = 9'd0;
			4'd2:    off = 9'd31;
			4'd3:    off = 9'd59;
			4'd4:    off = 9'd90;
			4'd5:    off = 9'd120;
			4'd6:    off = 9'd151;
			4'd7:    off = 9'd181;
			4'd8:    off = 9'd212;
			4'd9:    off = 9'd243;
			4'd10:   off = 9'd273;
			4'd11:   off = 9'd304;
			4'd12:   off = 9'd334;
			default: off = 9'd0;
		endcase
		if (leap && (m > 4'd2)) begin
			off = off + 9'd1;
		end
		return off;
	endfunction

endpackage

>>> design/dtdc_decode.sv
// Decode stage: checks the date, finds the leap year and splits the day count
// into year, leap, month and day terms. Depends on dtdc_pkg.
module dtdc_decode import dtdc_pkg::*; (
	input  logic [11:0] year,
	input  logic [3:0]  month,
	input  logic [4:0]  day,
	input  logic        calendar_mode,
	output dtdc_part_t  part
);

	logic        year_ok;
	logic [11:0] year_rel;
	logic [11:0] prev_year;
	logic [9:0]  pq;
	logic [5:0]  p100;
	logic [5:0]  p400;
	logic [10:0] leap_sum;
	logic [9:0]  yq;
	logic [5:0]  y25;
	logic [7:0]  yqq;
	logic [5:0]  yqq25;
	logic [9:0]  y25x;
	logic [9:0]  yqq25x;
	logic        div4;
	logic        div100;
	logic        div400;
	logic        leap;
	logic        greg;
	logic        bad_date;
	logic [21:0] year_prod;

	assign greg      = (calendar_mode == CalGregorian);
	assign year_ok   = (year >= BaseYear);
	assign year_rel  = year - BaseYear;
	assign prev_year = year - 12'd1;

	// Leap years in 1..year-1, less those in 1..1899.
	assign pq       = prev_year[11:2];
	assign p100     = div25(pq);
	assign p400     = div25({2'd0, pq[9:2]});
	assign leap_sum = {1'b0, pq} - {5'd0, p100} + {5'd0, p400} - LeapsBefore;

	// Leap test on the year itself.
	assign yq     = year[11:2];
	assign y25    = div25(yq);
	assign yqq    = yq[9:2];
	assign yqq25  = div25({2'd0, yqq});
	assign y25x   = 10'({4'd0, y25} * 10'd25);
	assign yqq25x = 10'({4'd0, yqq25} * 10'd25);
	assign div4   = (year[1:0] == 2'd0);
	assign div100 = div4 && (yq == y25x);
	assign div400 = div4 && (yq[1:0] == 2'd0) && ({2'd0, yqq} == yqq25x);
	assign leap   = greg && ((div4 && !div100) || div400);

	assign bad_date = (month < 4'd1) || (month > 4'd12) || (day < 5'd1) ||
		(day > month_len(month, leap));

	assign year_prod = {10'd0, year_rel} * {13'd0, DaysCommon};

	always_comb begin
		part.year_days  = year_prod[19:0];
		part.leap_days  = greg ? leap_sum[9:0] : 10'd0;
		part.month_days = month_start(month, leap);
		part.day_off    = day - 5'd1;
		part.use_count  = year_ok && !bad_date;
		part.bad        = year_ok && bad_date;
	end

endmodule

>>> design/dtdc_accum.sv
// Summing stage: adds the year, leap, month and day terms into the final count
// and forces zero for early years and bad dates. Depends on dtdc_pkg.
module dtdc_accum import dtdc_pkg::*; (
	input  dtdc_part_t  part,
	output logic [19:0] day_count,
	output logic        invalid
);

	logic [19:0] total;

	assign total = part.year_days + {10'd0, part.leap_days} + {11'd0, part.month_days} +
		{15'd0, part.day_off};

	assign day_count = part.use_count ? total : 20'd0;
	assign invalid   = part.bad;

endmodule

>>> design/date_to_day_count_unit.sv
// Top level of the date to day count unit: handshakes, mode register and the
// two pipeline stages. Depends on dtdc_pkg, dtdc_decode and dtdc_accum.
//
//  channel  | signals                           | word
//  ---------+-----------------------------------+-------------------------
//  in       | in_valid, in_ready                | year, month, day
//  out      | out_valid, out_ready              | day_count, invalid
//  cfg      | cfg_valid, cfg_ready              | cfg_data (calendar_mode)
//
// Each word passes from input to output through a decode register and a result
// register, and one word can be accepted every cycle while out_ready is high.
// A stalled output holds its word while an empty decode register can still take one.
// Reset clears the valid flags of both stages and sets the mode to Gregorian.
// Configuration writes are always taken.
module date_to_day_count_unit import dtdc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [11:0] year,
	input  logic [3:0]  month,
	input  logic [4:0]  day,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [19:0] day_count,
	output logic        invalid,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data
);

	logic        calendar_mode_q;
	logic        valid_s1;
	logic        valid_s2;
	dtdc_part_t  part;
	dtdc_part_t  part_s1;
	logic [19:0] count_next;
	logic        invalid_next;
	logic [19:0] day_count_s2;
	logic        invalid_s2;
	logic        adv1;
	logic        adv2;

	assign cfg_ready = 1'b1;
	assign adv2      = !valid_s2 || out_ready;
	assign adv1      = !valid_s1 || adv2;
	assign in_ready  = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calendar_mode_q <= CalGregorian;
		end else if (cfg_valid && cfg_ready) begin
			calendar_mode_q <= cfg_data;
		end
	end

	dtdc_decode u_decode (
		.year          (year),
		.month         (month),
		.day           (day),
		.calendar_mode (calendar_mode_q),
		.part          (part)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv1) begin
				valid_s1 <= in_valid;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			part_s1 <= part;
		end
	end

	dtdc_accum u_accum (
		.part      (part_s1),
		.day_count (count_next),
		.invalid   (invalid_next)
	);

	always_ff @(posedge clk) begin
		if (adv2 && valid_s1) begin
			day_count_s2 <= count_next;
			invalid_s2   <= invalid_next;
		end
	end

	assign out_valid = valid_s2;
	assign day_count = day_count_s2;
	assign invalid   = invalid_s2;

endmodule
